[sv/cnp_pkg.sv]
// ----------------------------------------------------------------------------
// cnp_pkg
// Shared types and codes for the credential negotiation parser.
// ----------------------------------------------------------------------------
package cnp_pkg;

    // length limits for the two length bytes (a length at or above is an error)
    localparam int NAME_LIMIT = 256;
    localparam int PASS_LIMIT = 256;

    // result status codes
    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_SUCCESS    = 2'd1;
    localparam logic [1:0] ST_ERROR      = 2'd2;

    // stored field kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_PASS = 2'd2;

    // input actions
    localparam logic ACT_FEED    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    // parser phases
    typedef enum logic [2:0] {
        PH_VERSION   = 3'd0,
        PH_NAME_LEN  = 3'd1,
        PH_NAME_DATA = 3'd2,
        PH_PASS_LEN  = 3'd3,
        PH_PASS_DATA = 3'd4,
        PH_DONE      = 3'd5,
        PH_ERROR     = 3'd6
    } cnp_phase_t;

    // command class decided by the front end
    typedef enum logic {
        OP_FEED    = 1'b0,
        OP_RESTART = 1'b1
    } cnp_op_t;

    // input item
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } cnp_in_t;

    // result item
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] field_kind;
        logic [7:0] field_index;
        logic [7:0] field_byte;
        logic [7:0] name_length;
        logic [7:0] pass_length;
    } cnp_out_t;

    // classified command between front and back
    typedef struct packed {
        cnp_op_t    op;
        logic [7:0] data;
    } cnp_cmd_t;

endpackage

[sv/cnp_front.sv]
// ----------------------------------------------------------------------------
// cnp_front
// Input stage: accepts items, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module cnp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cnp_pkg::cnp_in_t  in_item,
    output logic              push_valid,
    input  logic              push_ready,
    output cnp_pkg::cnp_cmd_t push_cmd
);
    import cnp_pkg::*;

    logic     hold_valid_reg;
    cnp_cmd_t hold_reg;
    cnp_cmd_t cmd_next;

    // classify the incoming item
    always_comb
    begin
        cmd_next.op   = (in_item.action == ACT_RESTART) ? OP_RESTART : OP_FEED;
        cmd_next.data = (in_item.action == ACT_RESTART) ? 8'd0 : in_item.data_byte;
    end

    // stage takes a new item whenever it is empty or drains this cycle
    assign in_ready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_reg <= cmd_next;
        end
    end

endmodule

[sv/cnp_queue.sv]
// ----------------------------------------------------------------------------
// cnp_queue
// Short command queue decoupling the front end from the parser.
// ----------------------------------------------------------------------------
module cnp_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  cnp_pkg::cnp_cmd_t push_cmd,
    output logic              pop_valid,
    input  logic              pop_ready,
    output cnp_pkg::cnp_cmd_t pop_cmd
);
    import cnp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cnp_cmd_t         slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    // fill count stays within the queue depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

[sv/cnp_back.sv]
// ----------------------------------------------------------------------------
// cnp_back
// Parser state machine with version register and registered result output.
// ----------------------------------------------------------------------------
module cnp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [7:0]        cfg_data,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cnp_pkg::cnp_cmd_t cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output cnp_pkg::cnp_out_t out_item
);
    import cnp_pkg::*;

    logic [7:0] version_reg;
    cnp_phase_t phase_reg,    phase_next;
    logic [7:0] name_len_reg, name_len_next;
    logic [7:0] name_pos_reg, name_pos_next;
    logic [7:0] pass_len_reg, pass_len_next;
    logic [7:0] pass_pos_reg, pass_pos_next;
    logic       out_valid_reg;
    cnp_out_t   out_reg,      out_next;
    logic       take;
    logic [7:0] pos_inc;

    // take a command whenever the result register is free or drains
    assign cmd_ready = !out_valid_reg || out_ready;
    assign take      = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= 8'd1;
        end
        else if (cfg_write)
        begin
            version_reg <= cfg_data;
        end
    end

    // next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        name_len_next = name_len_reg;
        name_pos_next = name_pos_reg;
        pass_len_next = pass_len_reg;
        pass_pos_next = pass_pos_reg;
        pos_inc       = 8'd0;
        out_next      = '0;
        out_next.status = ST_INCOMPLETE;

        if (cmd.op == OP_RESTART)
        begin
            phase_next    = PH_VERSION;
            name_len_next = 8'd0;
            name_pos_next = 8'd0;
            pass_len_next = 8'd0;
            pass_pos_next = 8'd0;
        end
        else
        begin
            case (phase_reg)
                PH_VERSION:
                begin
                    if (cmd.data == version_reg)
                    begin
                        phase_next = PH_NAME_LEN;
                    end
                    else
                    begin
                        phase_next      = PH_ERROR;
                        out_next.status = ST_ERROR;
                    end
                end
                PH_NAME_LEN:
                begin
                    if ({1'b0, cmd.data} >= 9'(NAME_LIMIT))
                    begin
                        phase_next      = PH_ERROR;
                        out_next.status = ST_ERROR;
                    end
                    else
                    begin
                        name_len_next = cmd.data;
                        name_pos_next = 8'd0;
                        phase_next    = (cmd.data == 8'd0) ? PH_PASS_LEN : PH_NAME_DATA;
                    end
                end
                PH_NAME_DATA:
                begin
                    pos_inc              = name_pos_reg + 8'd1;
                    out_next.field_kind  = KIND_NAME;
                    out_next.field_index = name_pos_reg;
                    out_next.field_byte  = cmd.data;
                    name_pos_next        = pos_inc;
                    if (pos_inc >= name_len_reg)
                    begin
                        phase_next = PH_PASS_LEN;
                    end
                end
                PH_PASS_LEN:
                begin
                    if ({1'b0, cmd.data} >= 9'(PASS_LIMIT))
                    begin
                        phase_next      = PH_ERROR;
                        out_next.status = ST_ERROR;
                    end
                    else
                    begin
                        pass_len_next = cmd.data;
                        pass_pos_next = 8'd0;
                        if (cmd.data == 8'd0)
                        begin
                            phase_next      = PH_DONE;
                            out_next.status = ST_SUCCESS;
                        end
                        else
                        begin
                            phase_next = PH_PASS_DATA;
                        end
                    end
                end
                PH_PASS_DATA:
                begin
                    pos_inc              = pass_pos_reg + 8'd1;
                    out_next.field_kind  = KIND_PASS;
                    out_next.field_index = pass_pos_reg;
                    out_next.field_byte  = cmd.data;
                    pass_pos_next        = pos_inc;
                    if (pos_inc >= pass_len_reg)
                    begin
                        phase_next      = PH_DONE;
                        out_next.status = ST_SUCCESS;
                    end
                end
                PH_DONE:
                begin
                    out_next.status = ST_SUCCESS;
                end
                default:
                begin
                    // error phase and unused codes
                    phase_next      = PH_ERROR;
                    out_next.status = ST_ERROR;
                end
            endcase
        end

        out_next.name_length = name_len_next;
        out_next.pass_length = pass_len_next;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_VERSION;
            name_len_reg <= 8'd0;
            name_pos_reg <= 8'd0;
            pass_len_reg <= 8'd0;
            pass_pos_reg <= 8'd0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            name_len_reg <= name_len_next;
            name_pos_reg <= name_pos_next;
            pass_len_reg <= pass_len_next;
            pass_pos_reg <= pass_pos_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            out_valid_reg <= cmd_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

    // a success result leaves the parser in the done phase
    a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ST_SUCCESS |-> phase_reg == PH_DONE)
        else $error("success result without done phase");

    // an error result leaves the parser in the error phase
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ST_ERROR |-> phase_reg == PH_ERROR)
        else $error("error result without error phase");

    // reported lengths track the parser state
    a_len_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.name_length == name_len_reg
                          && out_reg.pass_length == pass_len_reg)
        else $error("result lengths differ from parser state");

    // position never passes the received length while collecting name bytes
    a_name_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_NAME_DATA |-> name_pos_reg < name_len_reg)
        else $error("name position beyond length");

endmodule

[sv/credential_negotiation_parser.sv]
// ----------------------------------------------------------------------------
// credential_negotiation_parser
// Byte-wise parser for a username/password negotiation message.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output stalls, and returns one result
// item per input item, in order. Each item is either a stream byte or a
// restart. The stream is a version byte (checked against expected_version,
// reset value 1), a username length and bytes, then a password length and
// bytes; every result carries the status (incomplete, success, error), for a
// username or password byte the echoed byte with its index, and both lengths
// received so far. Error and done stay until a restart. A result passes from
// the input stage register through a command queue slot to the result
// register. The queue holds up to FIFO_DEPTH commands so the input side
// keeps taking items while a result waits, until the queue fills. Write
// expected_version only while idle.
// ----------------------------------------------------------------------------
module credential_negotiation_parser #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  cnp_pkg::cnp_in_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output cnp_pkg::cnp_out_t out_item
);
    import cnp_pkg::*;

    logic     push_valid;
    logic     push_ready;
    cnp_cmd_t push_cmd;
    logic     pop_valid;
    logic     pop_ready;
    cnp_cmd_t pop_cmd;

    // accept and classify
    cnp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // command queue
    cnp_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // parser and result register
    cnp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
